[rtl/pbm_pkg.sv]
`timescale 1ns / 1ps

package pbm_pkg;

    // blend mode codes
    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_DIFF  = 3'd1;
    localparam logic [2:0] MODE_MUL   = 3'd2;
    localparam logic [2:0] MODE_SPLIT = 3'd3;
    localparam logic [2:0] MODE_PASS  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_BLEND_MODE = 2'd0;
    localparam logic [1:0] CFG_ALPHA_Q8   = 2'd1;
    localparam logic [1:0] CFG_LINE_WIDTH = 2'd2;

    // register widths and reset values
    localparam int CfgDataW = 13;
    localparam logic [2:0]  RST_BLEND_MODE = MODE_ADD;
    localparam logic [8:0]  RST_ALPHA_Q8   = 9'd256;
    localparam logic [12:0] RST_LINE_WIDTH = 13'd640;

    // full strength alpha and the split threshold
    localparam logic [8:0] ALPHA_FULL = 9'd256;
    localparam logic [8:0] ALPHA_HALF = 9'd128;

    localparam int DEF_MAX_WIDTH = 4096;

    // input beat
    typedef struct packed {
        logic [7:0]  dst_red;
        logic [7:0]  dst_green;
        logic [7:0]  dst_blue;
        logic [7:0]  src_red;
        logic [7:0]  src_green;
        logic [7:0]  src_blue;
        logic [11:0] column;
        logic        frame_end_in;
    } t_pix_in;

    // output beat
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end_out;
    } t_pix_out;

    // stage load enables shared by all colour lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_stage_ctl;

endpackage

[rtl/pbm_channel.sv]
`timescale 1ns / 1ps

module pbm_channel (
    input  logic                  i_clk,
    input  pbm_pkg::t_stage_ctl   i_ctl,
    input  logic [2:0]            i_mode,
    input  logic [8:0]            i_alpha,
    input  logic                  i_copy,
    input  logic [7:0]            i_dst,
    input  logic [7:0]            i_src,
    output logic [7:0]            o_pix
);

    // stage 1: source scaled by alpha
    logic [7:0]  r_d1;
    logic [7:0]  r_s1;
    logic [15:0] r_sa1;
    logic        r_copy1;

    // stage 2: add, difference and the wide product
    logic [7:0]  r_d2;
    logic [7:0]  r_s2;
    logic        r_copy2;
    logic [7:0]  r_add2;
    logic [7:0]  r_diff2;
    logic [23:0] r_prod2;

    // stage 3: selected result
    logic [7:0]  r_pix3;

    logic [15:0] n_sa;
    logic [16:0] n_sum;
    logic [15:0] n_d8;
    logic [15:0] n_absdiff;
    logic [23:0] n_prod;
    logic [15:0] n_quo_in;
    logic [8:0]  n_rem;
    logic [7:0]  n_mul;
    logic [7:0]  n_pix;

    assign n_sa = 16'(i_src) * 16'(i_alpha);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_d1    <= i_dst;
            r_s1    <= i_src;
            r_sa1   <= n_sa;
            r_copy1 <= i_copy;
        end
    end

    // stage 2 arithmetic on d*256 against s*a
    always_comb begin
        n_d8      = {r_d1, 8'h00};
        n_sum     = 17'(n_d8) + 17'(r_sa1);
        n_absdiff = (n_d8 >= r_sa1) ? (n_d8 - r_sa1) : (r_sa1 - n_d8);
        n_prod    = 24'(r_d1) * 24'(r_sa1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_d2    <= r_d1;
            r_s2    <= r_s1;
            r_copy2 <= r_copy1;
            r_add2  <= n_sum[16] ? 8'hff : n_sum[15:8];
            r_diff2 <= n_absdiff[15:8];
            r_prod2 <= n_prod;
        end
    end

    // product / (255*256): drop 8 bits, then divide by 255 with one correction
    always_comb begin
        n_quo_in = r_prod2[23:8];
        n_rem    = 9'(n_quo_in[7:0]) + 9'(n_quo_in[15:8]);
        n_mul    = n_quo_in[15:8] + ((n_rem >= 9'd255) ? 8'd1 : 8'd0);
    end

    // mode select
    always_comb begin
        if (r_copy2) begin
            n_pix = r_s2;
        end else begin
            case (i_mode)
                pbm_pkg::MODE_ADD:  n_pix = r_add2;
                pbm_pkg::MODE_DIFF: n_pix = r_diff2;
                pbm_pkg::MODE_MUL:  n_pix = n_mul;
                default:            n_pix = r_d2;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_pix3 <= n_pix;
        end
    end

    assign o_pix = r_pix3;

endmodule

[rtl/pixel_blend_modes_core.sv]
`timescale 1ns / 1ps
// pixel blend compositor, one rgb pixel per beat
// input channel: i_in_valid / o_in_ready carry a destination pixel, a source
// pixel, the pixel's column and a frame end marker (pbm_pkg::t_pix_in)
// output channel: o_out_valid / i_out_ready carry the blended pixel and the
// copied frame end marker (pbm_pkg::t_pix_out)
// configuration: i_cfg_we writes register i_cfg_idx (0 blend mode, 1 alpha
// in q8, 2 line width) with i_cfg_data; write only while no beat is in flight
// pipeline: the three register stages (alpha scale, wide product and add/diff,
// divide by 255 and mode select) lie between input beat and output valid;
// throughput is one pixel per cycle while i_out_ready stays high
// stall: o_in_ready is high while any stage holds a bubble; with all three
// stages full and i_out_ready low the pipeline freezes and nothing is lost
// reset: valid bits clear, registers return to add mode, full alpha and a
// line width of 640
module pixel_blend_modes_core #(
    parameter int MAX_WIDTH = pbm_pkg::DEF_MAX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [pbm_pkg::CfgDataW-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  pbm_pkg::t_pix_in                 i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output pbm_pkg::t_pix_out                o_out_data
);

    logic [2:0]  r_blend_mode;
    logic [8:0]  r_alpha_q8;
    logic [12:0] r_line_width;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_fe1;
    logic r_fe2;
    logic r_fe3;

    pbm_pkg::t_stage_ctl n_ctl;
    logic [8:0]  n_alpha_eff;
    logic [12:0] n_width;
    logic [11:0] n_half;
    logic        n_copy;
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode <= pbm_pkg::RST_BLEND_MODE;
            r_alpha_q8   <= pbm_pkg::RST_ALPHA_Q8;
            r_line_width <= pbm_pkg::RST_LINE_WIDTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pbm_pkg::CFG_BLEND_MODE: r_blend_mode <= i_cfg_data[2:0];
                pbm_pkg::CFG_ALPHA_Q8:   r_alpha_q8   <= i_cfg_data[8:0];
                pbm_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        n_ctl.en3 = !r_v3 || i_out_ready;
        n_ctl.en2 = !r_v2 || n_ctl.en3;
        n_ctl.en1 = !r_v1 || n_ctl.en2;
    end

    assign o_in_ready = n_ctl.en1;

    // alpha above full strength is full strength
    assign n_alpha_eff = (r_alpha_q8 >= pbm_pkg::ALPHA_FULL) ? pbm_pkg::ALPHA_FULL
                                                              : r_alpha_q8;

    // split screen column range from the clamped line width
    always_comb begin
        if (32'(r_line_width) > MAX_WIDTH) begin
            n_width = 13'(MAX_WIDTH);
        end else begin
            n_width = r_line_width;
        end
        n_half = n_width[12:1];
        n_copy = (r_blend_mode == pbm_pkg::MODE_SPLIT)
              && (r_alpha_q8 > pbm_pkg::ALPHA_HALF)
              && (i_in_data.column >= n_half)
              && (13'(i_in_data.column) < {n_half, 1'b0});
    end

    // valid bits and frame end marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (n_ctl.en1) begin
                r_v1 <= i_in_valid;
            end
            if (n_ctl.en2) begin
                r_v2 <= r_v1;
            end
            if (n_ctl.en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_ctl.en1) begin
            r_fe1 <= i_in_data.frame_end_in;
        end
        if (n_ctl.en2) begin
            r_fe2 <= r_fe1;
        end
        if (n_ctl.en3) begin
            r_fe3 <= r_fe2;
        end
    end

    // colour lanes
    pbm_channel u_red (
        .i_clk   (i_clk),
        .i_ctl   (n_ctl),
        .i_mode  (r_blend_mode),
        .i_alpha (n_alpha_eff),
        .i_copy  (n_copy),
        .i_dst   (i_in_data.dst_red),
        .i_src   (i_in_data.src_red),
        .o_pix   (n_red)
    );

    pbm_channel u_green (
        .i_clk   (i_clk),
        .i_ctl   (n_ctl),
        .i_mode  (r_blend_mode),
        .i_alpha (n_alpha_eff),
        .i_copy  (n_copy),
        .i_dst   (i_in_data.dst_green),
        .i_src   (i_in_data.src_green),
        .o_pix   (n_green)
    );

    pbm_channel u_blue (
        .i_clk   (i_clk),
        .i_ctl   (n_ctl),
        .i_mode  (r_blend_mode),
        .i_alpha (n_alpha_eff),
        .i_copy  (n_copy),
        .i_dst   (i_in_data.dst_blue),
        .i_src   (i_in_data.src_blue),
        .o_pix   (n_blue)
    );

    assign o_out_valid              = r_v3;
    assign o_out_data.out_red       = n_red;
    assign o_out_data.out_green     = n_green;
    assign o_out_data.out_blue      = n_blue;
    assign o_out_data.frame_end_out = r_fe3;

    // back pressure only when every stage is full and the output stalls
    a_ready_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && !i_out_ready)
    ) else $error("input stalled with a bubble in the pipeline");

    // an unstalled beat reaches the output with its frame end marker
    a_latency_three: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_out_ready) ##1 i_out_ready ##1 i_out_ready
        |=> o_out_valid && (o_out_data.frame_end_out == $past(i_in_data.frame_end_in, 3))
    ) else $error("beat lost or frame end marker wrong after three cycles");

    // pass through mode gives the destination; red and blue are checked
    a_pass_through: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ((i_in_valid && o_in_ready && i_out_ready
          && r_blend_mode == pbm_pkg::MODE_PASS) ##1 i_out_ready ##1 i_out_ready)
        |=> (o_out_data.out_red == $past(i_in_data.dst_red, 3))
         && (o_out_data.out_blue == $past(i_in_data.dst_blue, 3))
    ) else $error("pass through mode altered the destination");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import pbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_PCT       = 31;
    localparam int PHASES         = 14;
    localparam int PHASE_BEATS    = 125;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;

    // codes the package leaves unnamed: a spare register slot and a reserved mode
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic [2:0] MODE_RSVD = 3'd7;

    // one directed row: settings, pixel, and optionally a hand-typed answer
    typedef struct {
        logic [2:0]  mode;
        logic [8:0]  alpha;
        logic [12:0] width;
        t_pix_in     px;
        bit          typed;
        t_pix_out    want;
    } t_probe;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_cfg_we   = 1'b0;
    logic [1:0]          i_cfg_idx  = CFG_BLEND_MODE;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_pix_in             i_in_data  = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_pix_out            o_out_data;

    // shadow copy of the blend settings
    logic [2:0]  cfg_mode  = RST_BLEND_MODE;
    logic [8:0]  cfg_alpha = RST_ALPHA_Q8;
    logic [12:0] cfg_width = RST_LINE_WIDTH;

    t_pix_out pending_pix[$];
    t_probe   probes[$];
    bit       row_typed = 1'b0;
    t_pix_out row_want  = '0;

    int mismatches   = 0;
    int results_seen = 0;
    int stall_cycles = 0;
    int in_idle_pct  = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;
    bit squeeze      = 1'b0;
    bit squeeze_done = 1'b0;

    pixel_blend_modes_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // one colour lane: q8 fade of the source, then the selected blend
    function automatic logic [7:0] mix_channel(logic [7:0] d, logic [7:0] s);
        int unsigned dd, ss, sa, v;
        dd = d;
        ss = s;
        if (cfg_alpha >= ALPHA_FULL) begin
            case (cfg_mode)
                MODE_ADD:  v = (dd + ss > 255) ? 255 : dd + ss;
                MODE_DIFF: v = (dd >= ss) ? dd - ss : ss - dd;
                MODE_MUL:  v = (dd * ss) / 255;
                default:   v = dd;
            endcase
        end else begin
            sa = ss * cfg_alpha;
            case (cfg_mode)
                MODE_ADD: begin
                    v = ((dd << 8) + sa) >> 8;
                    if (v > 255) v = 255;
                end
                MODE_DIFF: v = (((dd << 8) >= sa) ? (dd << 8) - sa : sa - (dd << 8)) >> 8;
                MODE_MUL:  v = (dd * sa) / (255 * 256);
                default:   v = dd;
            endcase
        end
        return v[7:0];
    endfunction

    // whole pixel, including the split screen copy of the source
    function automatic t_pix_out blend_pixel(t_pix_in px);
        t_pix_out    res;
        int unsigned w, half;
        bit          take_src;
        w        = (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_width;
        half     = w >> 1;
        take_src = (cfg_mode == MODE_SPLIT) && (cfg_alpha > ALPHA_HALF) &&
                   (px.column >= half) && (px.column < 2 * half);
        if (take_src) begin
            res.out_red   = px.src_red;
            res.out_green = px.src_green;
            res.out_blue  = px.src_blue;
        end else begin
            res.out_red   = mix_channel(px.dst_red, px.src_red);
            res.out_green = mix_channel(px.dst_green, px.src_green);
            res.out_blue  = mix_channel(px.dst_blue, px.src_blue);
        end
        res.frame_end_out = px.frame_end_in;
        return res;
    endfunction

    function automatic t_probe probe(logic [2:0] m, logic [8:0] a, logic [12:0] w,
                                     logic [23:0] dst, logic [23:0] src, logic [11:0] col,
                                     logic fe, bit typed, logic [23:0] want);
        t_probe r;
        r.mode  = m;
        r.alpha = a;
        r.width = w;
        r.px    = {dst, src, col, fe};
        r.typed = typed;
        r.want  = {want, fe};
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // settings go in while the pipe is empty; the spare slot gets junk first
    task automatic load_cfg(input logic [2:0] m, input logic [8:0] a, input logic [12:0] w);
        logic [CfgDataW-1:0] junk;
        junk = CfgDataW'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= junk;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BLEND_MODE;
        i_cfg_data <= {junk[CfgDataW-1:3], m};
        cfg_mode   = m;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ALPHA_Q8;
        i_cfg_data <= {junk[CfgDataW-1:9], a};
        cfg_alpha  = a;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LINE_WIDTH;
        i_cfg_data <= w;
        cfg_width  = w;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // offer one beat after a random gap, hold it until taken
    task automatic offer_pixel(input t_pix_in px, input bit typed, input t_pix_out want);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_pix.size() != 0);
    endtask

    // receiver: random back-pressure plus one long hold-off
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (squeeze && !squeeze_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                squeeze_done = 1'b1;
            end
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // scoreboard: predict on input beats, compare on output beats
    always @(posedge i_clk) begin : scoreboard
        t_pix_out want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                pending_pix.push_back(row_typed ? row_want : blend_pixel(i_in_data));
            if (o_out_valid && i_out_ready) begin
                if (pending_pix.size() == 0) begin
                    report_mismatch($sformatf("beat with nothing pending: %h", o_out_data));
                end else begin
                    want = pending_pix.pop_front();
                    if (o_out_data.out_red !== want.out_red)
                        report_mismatch($sformatf("beat %0d red %h, want %h", results_seen,
                                                  o_out_data.out_red, want.out_red));
                    if (o_out_data.out_green !== want.out_green)
                        report_mismatch($sformatf("beat %0d green %h, want %h", results_seen,
                                                  o_out_data.out_green, want.out_green));
                    if (o_out_data.out_blue !== want.out_blue)
                        report_mismatch($sformatf("beat %0d blue %h, want %h", results_seen,
                                                  o_out_data.out_blue, want.out_blue));
                    if (o_out_data.frame_end_out !== want.frame_end_out)
                        report_mismatch($sformatf("beat %0d frame end %b, want %b",
                                                  results_seen, o_out_data.frame_end_out,
                                                  want.frame_end_out));
                end
                results_seen++;
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d beats pending", pending_pix.size());
            $display("pixel_blend_modes_core verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        t_pix_in     px;
        logic [2:0]  m;
        logic [8:0]  a;
        logic [12:0] w;
        int          lim;
        logic [8:0]  alpha_pick [10] = '{256, 0, 128, 129, 255, 511, 1, 257, 64, 200};
        logic [12:0] width_pick [10] = '{640, 1, 0, 2, 4096, 4097, 8191, 3, 16, 33};

        // directed rows; the first runs on the reset settings
        probes.push_back(probe(MODE_ADD, 256, 640, 24'h000000, 24'h000000, 0, 0, 1, 24'h000000));
        probes.push_back(probe(MODE_ADD, 256, 640, 24'hFFFFFF, 24'hFFFFFF, 4095, 1, 1,
                               24'hFFFFFF));
        probes.push_back(probe(MODE_ADD, 256, 640, 24'h64C80A, 24'h646405, 2, 0, 0, 0));
        probes.push_back(probe(MODE_DIFF, 256, 640, 24'h000000, 24'hFFFFFF, 5, 0, 1,
                               24'hFFFFFF));
        probes.push_back(probe(MODE_DIFF, 256, 640, 24'hFFFFFF, 24'h000000, 6, 1, 1,
                               24'hFFFFFF));
        probes.push_back(probe(MODE_MUL, 256, 640, 24'hFFFFFF, 24'hFFFFFF, 7, 0, 1, 24'hFFFFFF));
        probes.push_back(probe(MODE_MUL, 256, 640, 24'hFFFFFF, 24'h000000, 8, 0, 1, 24'h000000));
        // zero alpha leaves the destination alone
        probes.push_back(probe(MODE_ADD, 0, 640, 24'h123456, 24'hFFFFFF, 9, 0, 1, 24'h123456));
        probes.push_back(probe(MODE_ADD, 128, 640, 24'h80FF01, 24'hFF80FE, 10, 0, 0, 0));
        probes.push_back(probe(MODE_DIFF, 200, 640, 24'h10F080, 24'hF01080, 11, 0, 0, 0));
        probes.push_back(probe(MODE_MUL, 255, 640, 24'hFFFFFF, 24'hFFFFFF, 12, 1, 0, 0));
        // alpha above full strength is treated as full
        probes.push_back(probe(MODE_ADD, 511, 640, 24'hC8C8C8, 24'h646464, 1, 1, 1, 24'hFFFFFF));
        // split screen edges
        probes.push_back(probe(MODE_SPLIT, 256, 640, 24'h111111, 24'hEEEEEE, 319, 0, 1,
                               24'h111111));
        probes.push_back(probe(MODE_SPLIT, 256, 640, 24'h111111, 24'hEEEEEE, 320, 0, 1,
                               24'hEEEEEE));
        probes.push_back(probe(MODE_SPLIT, 256, 640, 24'h111111, 24'hEEEEEE, 639, 1, 1,
                               24'hEEEEEE));
        probes.push_back(probe(MODE_SPLIT, 256, 640, 24'h111111, 24'hEEEEEE, 640, 0, 1,
                               24'h111111));
        probes.push_back(probe(MODE_SPLIT, 128, 640, 24'h111111, 24'hEEEEEE, 320, 0, 1,
                               24'h111111));
        probes.push_back(probe(MODE_SPLIT, 129, 640, 24'h111111, 24'hEEEEEE, 320, 0, 1,
                               24'hEEEEEE));
        // widths of one and zero have no split range
        probes.push_back(probe(MODE_SPLIT, 256, 1, 24'h111111, 24'hEEEEEE, 0, 0, 1, 24'h111111));
        probes.push_back(probe(MODE_SPLIT, 256, 0, 24'h111111, 24'hEEEEEE, 0, 1, 1, 24'h111111));
        // oversize width saturates to the maximum line
        probes.push_back(probe(MODE_SPLIT, 256, 8191, 24'h111111, 24'hEEEEEE, 2047, 0, 1,
                               24'h111111));
        probes.push_back(probe(MODE_SPLIT, 256, 8191, 24'h111111, 24'hEEEEEE, 4095, 0, 1,
                               24'hEEEEEE));
        probes.push_back(probe(MODE_SPLIT, 256, 5, 24'h111111, 24'hEEEEEE, 4, 0, 1, 24'h111111));
        probes.push_back(probe(MODE_PASS, 256, 640, 24'hABCDEF, 24'h123456, 3, 0, 1,
                               24'hABCDEF));
        // unknown mode falls back to the destination
        probes.push_back(probe(MODE_RSVD, 100, 640, 24'h5A5AA5, 24'hC3C33C, 13, 1, 1,
                               24'h5A5AA5));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (probes[i]) begin
            if (probes[i].mode != cfg_mode || probes[i].alpha != cfg_alpha ||
                probes[i].width != cfg_width) begin
                drain_pipe();
                load_cfg(probes[i].mode, probes[i].alpha, probes[i].width);
            end
            offer_pixel(probes[i].px, probes[i].typed, probes[i].want);
        end

        // random phases, each on its own settings
        for (int p = 0; p < PHASES; p++) begin
            drain_pipe();
            if (p < 8)
                m = 3'(p);
            else
                m = (p % 2) ? MODE_SPLIT : 3'($urandom_range(0, 7));
            a = (p < 10) ? alpha_pick[p] : 9'($urandom_range(0, 511));
            w = (p < 10) ? width_pick[p] : 13'($urandom_range(1, 64));
            load_cfg(m, a, w);
            in_idle_pct  = (p == 3 || p == 5) ? 0 : IDLE_PCT;
            out_idle_pct = (p == 5) ? 0 : IDLE_PCT;
            squeeze      = (p == 3);
            lim = (w + 3 > 4095) ? 4095 : w + 3;
            repeat (PHASE_BEATS) begin
                px.dst_red      = rand_byte();
                px.dst_green    = rand_byte();
                px.dst_blue     = rand_byte();
                px.src_red      = rand_byte();
                px.src_green    = rand_byte();
                px.src_blue     = rand_byte();
                // half the columns sit near the split range
                px.column       = $urandom_range(1) ? 12'($urandom_range(0, lim))
                                                    : 12'($urandom_range(0, 4095));
                px.frame_end_in = ($urandom_range(7) == 0);
                offer_pixel(px, 1'b0, '0);
            end
        end

        drain_pipe();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_pix.size() == 0) begin
            $display("pixel_blend_modes_core verification clean");
        end else begin
            $display("pixel_blend_modes_core verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/pbm_pkg.sv
rtl/pbm_channel.sv
rtl/pixel_blend_modes_core.sv
test/testbench.sv
